// File: hdl/fdcr_pkg.sv
// ----------------------------------------------------------------------------
// fdcr_pkg
// Shared types and constants of the floppy controller register core.
// ----------------------------------------------------------------------------
package fdcr_pkg;

   localparam int TRACKS            = 77;
   localparam int SECTORS_PER_TRACK = 26;
   localparam int SECTOR_BYTES      = 128;
   localparam int DRIVES            = 4;

   localparam int TRACK_BYTES = SECTORS_PER_TRACK * SECTOR_BYTES;
   localparam int DRIVE_BYTES = TRACKS * TRACK_BYTES;
   localparam int MEDIA_BYTES = DRIVES * DRIVE_BYTES;
   localparam int MEDIA_AW    = $clog2(MEDIA_BYTES);
   localparam int LANE_W      = 4;
   localparam int LANES       = 1 << LANE_W;
   localparam int MEDIA_ROWS  = (MEDIA_BYTES + LANES - 1) / LANES;
   localparam int ROW_W       = MEDIA_AW - LANE_W;
   localparam int BUF_DEPTH   = 128;
   localparam int BUF_AW      = $clog2(BUF_DEPTH);
   localparam int FPTR_W      = 12;
   localparam int CAP_W       = FPTR_W + 1;
   localparam int Q_DEPTH     = 2;
   localparam int Q_AW        = $clog2(Q_DEPTH);
   localparam int RADR_BYTES  = 6;

   // board status bits
   localparam logic [7:0] B_INT = 8'h02;
   localparam logic [7:0] B_IN  = 8'h04;
   localparam logic [7:0] B_OUT = 8'h08;

   // controller status bits
   localparam logic [7:0] S_TRK0 = 8'h04;
   localparam logic [7:0] S_CMD  = 8'h08;
   localparam logic [7:0] S_RNF  = 8'h10;
   localparam logic [7:0] S_WP   = 8'h40;
   localparam logic [7:0] S_NR   = 8'h80;

   // command codes, upper nibble
   localparam logic [3:0] CMD_RESTORE      = 4'h0;
   localparam logic [3:0] CMD_SEEK         = 4'h1;
   localparam logic [3:0] CMD_STEP         = 4'h2;
   localparam logic [3:0] CMD_STEP_UPD     = 4'h3;
   localparam logic [3:0] CMD_STEP_IN      = 4'h4;
   localparam logic [3:0] CMD_STEP_IN_UPD  = 4'h5;
   localparam logic [3:0] CMD_STEP_OUT     = 4'h6;
   localparam logic [3:0] CMD_STEP_OUT_UPD = 4'h7;
   localparam logic [3:0] CMD_READ         = 4'h8;
   localparam logic [3:0] CMD_READ_MULTI   = 4'h9;
   localparam logic [3:0] CMD_WRITE        = 4'ha;
   localparam logic [3:0] CMD_WRITE_MULTI  = 4'hb;
   localparam logic [3:0] CMD_GROUP_C      = 4'hc;
   localparam logic [3:0] CMD_FORCE_INT    = 4'hd;
   localparam logic [3:0] CMD_READ_TRACK   = 4'he;
   localparam logic [3:0] CMD_FORMAT       = 4'hf;
   localparam logic [7:0] CMD_READ_ADDR    = 8'hc4;

   localparam logic [7:0] MARK_DATA = 8'hfb;
   localparam logic [7:0] MARK_END  = 8'hf7;

   // bus ports
   localparam logic [2:0] PORT_BSTAT  = 3'd0;
   localparam logic [2:0] PORT_BCTL   = 3'd1;
   localparam logic [2:0] PORT_STATUS = 3'd2;
   localparam logic [2:0] PORT_TRACK  = 3'd3;
   localparam logic [2:0] PORT_SECTOR = 3'd4;
   localparam logic [2:0] PORT_DATA   = 3'd5;

   localparam logic CSR_DRIVE_PRESENT = 1'b0;
   localparam logic CSR_WRITE_PROTECT = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [2:0] port;
      logic [7:0] wdata;
   } req_type;

   typedef struct packed {
      logic [7:0] rdata;
      logic       irq_pending;
      logic [1:0] data_request;
   } rsp_type;

   typedef struct packed {
      logic [3:0] drive_present;
      logic [3:0] write_protect;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_NOP, OP_RD_BSTAT, OP_RD_BCTL, OP_RD_STATUS, OP_RD_TRACK, OP_RD_SECTOR,
      OP_RD_DATA, OP_WR_BCTL, OP_WR_CMD, OP_WR_TRACK, OP_WR_SECTOR, OP_WR_DATA
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] wdata;
   } item_type;

   typedef enum logic [2:0] {M_IDLE, M_READ, M_WRITE, M_RADR, M_FMT} mode_type;

   typedef enum logic [1:0] {BK_CLEAR, BK_RUN, BK_MEDRD, BK_COMMIT} bk_state_type;

endpackage

// File: hdl/fdcr_front.sv
// ----------------------------------------------------------------------------
// fdcr_front
// Accepts bus beats, decodes them into operations and queues them.
// ----------------------------------------------------------------------------
module fdcr_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  fdcr_pkg::req_type  req_data,
   input  logic               clear_busy,
   output logic               head_valid,
   output fdcr_pkg::item_type head,
   input  logic               pop
);
   import fdcr_pkg::*;

   item_type         q_ff [Q_DEPTH];
   logic [Q_AW-1:0]  wp_ff, rp_ff;
   logic [Q_AW:0]    cnt_ff;
   item_type         dec;
   logic             push;

   always_comb begin
      dec.wdata = req_data.wdata;
      dec.op    = OP_NOP;
      if (req_data.kind) begin
         case (req_data.port)
            PORT_BCTL:   dec.op = OP_WR_BCTL;
            PORT_STATUS: dec.op = OP_WR_CMD;
            PORT_TRACK:  dec.op = OP_WR_TRACK;
            PORT_SECTOR: dec.op = OP_WR_SECTOR;
            PORT_DATA:   dec.op = OP_WR_DATA;
            default:     dec.op = OP_NOP;
         endcase
      end else begin
         case (req_data.port)
            PORT_BSTAT:  dec.op = OP_RD_BSTAT;
            PORT_BCTL:   dec.op = OP_RD_BCTL;
            PORT_STATUS: dec.op = OP_RD_STATUS;
            PORT_TRACK:  dec.op = OP_RD_TRACK;
            PORT_SECTOR: dec.op = OP_RD_SECTOR;
            PORT_DATA:   dec.op = OP_RD_DATA;
            default:     dec.op = OP_NOP;
         endcase
      end
   end

   assign req_ready  = !clear_busy && (cnt_ff != (Q_AW+1)'(Q_DEPTH));
   assign push       = req_valid && req_ready;
   assign head_valid = (cnt_ff != '0);
   assign head       = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= Q_AW'(wp_ff + 1'b1);
         end
         if (pop) begin
            rp_ff <= Q_AW'(rp_ff + 1'b1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

// File: hdl/fdcr_back.sv
// ----------------------------------------------------------------------------
// fdcr_back
// Executes queued operations: register file, command decode, sector and
// format transfers, media memory and the result register.
// ----------------------------------------------------------------------------
module fdcr_back (
   input  logic               clock,
   input  logic               reset,
   input  fdcr_pkg::cfg_type  cfg,
   input  logic               head_valid,
   input  fdcr_pkg::item_type head,
   output logic               pop,
   output logic               clear_busy,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output fdcr_pkg::rsp_type  rsp_data
);
   import fdcr_pkg::*;

   logic [LANES-1:0][7:0] media_mem [MEDIA_ROWS];
   logic [7:0]            buf_mem [BUF_DEPTH];

   bk_state_type  state_ff, state_in;
   mode_type      mode_ff, mode_in;
   logic [7:0]    ctl_ff, ctl_in, trk_ff, trk_in, sec_ff, sec_in, dat_ff, dat_in;
   logic [7:0]    bstat_ff, bstat_in, bctl_ff, bctl_in, bc_ff, bc_in;
   logic [1:0]    drv_ff, drv_in, fphase_ff, fphase_in;
   logic [4:0]    fsec_ff, fsec_in;
   logic [FPTR_W-1:0] fptr_ff, fptr_in;
   logic [MEDIA_AW-1:0] latched_ff, latched_in;
   logic [7:0]    radr_sec_ff, radr_sec_in;
   logic [ROW_W-1:0] clr_row_ff, clr_row_in;
   logic [MEDIA_AW-1:0] cm_base_ff, cm_base_in;
   logic [7:0]    cm_len_ff, cm_len_in, cm_cnt_ff, cm_cnt_in, cm_idx_ff, cm_idx_in;
   logic [CAP_W-1:0] cm_cap_ff, cm_cap_in;
   logic          cm_wp_ff, cm_wp_in;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_load;

   logic [LANES-1:0][7:0] rd_row_ff;
   logic [LANE_W-1:0]     rd_lane_ff;
   logic [7:0]            buf_rd_ff;

   logic               media_re, media_we, buf_we, buf_re;
   logic [MEDIA_AW-1:0] media_raddr, media_waddr;
   logic [BUF_AW-1:0]   buf_waddr, buf_raddr;
   logic [7:0]          buf_wdata;

   logic                out_free, drive_ok, wprot, bad_sector;
   logic [MEDIA_AW-1:0] sec_addr, trk_base, xfer_addr;
   logic [7:0]          d, r, new_trk, st;
   logic [3:0]          hi;
   logic [2:0]          sel;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign clear_busy = (state_ff == BK_CLEAR);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign drive_ok   = (drv_ff < DRIVES) && cfg.drive_present[drv_ff];
   assign wprot      = cfg.write_protect[drv_ff];
   assign bad_sector = (trk_ff >= TRACKS) || (sec_ff == 8'd0) || (sec_ff > SECTORS_PER_TRACK);
   assign trk_base   = MEDIA_AW'(drv_ff) * MEDIA_AW'(DRIVE_BYTES)
                     + MEDIA_AW'(trk_ff) * MEDIA_AW'(TRACK_BYTES);
   assign sec_addr   = trk_base + (MEDIA_AW'(sec_ff) - 1'b1) * MEDIA_AW'(SECTOR_BYTES);
   assign media_waddr = cm_base_ff + MEDIA_AW'(cm_idx_ff);

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      ctl_in      = ctl_ff;
      trk_in      = trk_ff;
      sec_in      = sec_ff;
      dat_in      = dat_ff;
      bstat_in    = bstat_ff;
      bctl_in     = bctl_ff;
      bc_in       = bc_ff;
      drv_in      = drv_ff;
      fphase_in   = fphase_ff;
      fsec_in     = fsec_ff;
      fptr_in     = fptr_ff;
      latched_in  = latched_ff;
      radr_sec_in = radr_sec_ff;
      clr_row_in  = clr_row_ff;
      cm_base_in  = cm_base_ff;
      cm_len_in   = cm_len_ff;
      cm_cap_in   = cm_cap_ff;
      cm_cnt_in   = cm_cnt_ff;
      cm_idx_in   = cm_idx_ff;
      cm_wp_in    = cm_wp_ff;
      pop         = 1'b0;
      rsp_load    = 1'b0;
      rsp_in      = rsp_ff;
      media_re    = 1'b0;
      media_we    = 1'b0;
      media_raddr = latched_ff;
      buf_we      = 1'b0;
      buf_re      = 1'b0;
      buf_waddr   = bc_ff[BUF_AW-1:0];
      buf_raddr   = cm_cnt_ff[BUF_AW-1:0];
      d           = head.wdata;
      buf_wdata   = head.wdata;
      r           = 8'd0;
      hi          = head.wdata[7:4];
      new_trk     = trk_ff;
      st          = 8'd0;
      sel         = 3'd0;
      xfer_addr   = latched_ff;
      case (state_ff)
         BK_CLEAR: begin
            clr_row_in = ROW_W'(clr_row_ff + 1'b1);
            if (clr_row_ff == ROW_W'(MEDIA_ROWS - 1)) begin
               state_in = BK_RUN;
            end
         end
         BK_MEDRD: begin
            if (out_free) begin
               rsp_load            = 1'b1;
               rsp_in.rdata        = rd_row_ff[rd_lane_ff];
               rsp_in.irq_pending  = bstat_ff[1];
               rsp_in.data_request = bstat_ff[3:2];
               state_in            = BK_RUN;
            end
         end
         BK_COMMIT: begin
            media_we = cm_wp_ff && (CAP_W'(cm_idx_ff) < cm_cap_ff);
            if (cm_cnt_ff < cm_len_ff) begin
               buf_re    = 1'b1;
               cm_wp_in  = 1'b1;
               cm_idx_in = cm_cnt_ff;
               cm_cnt_in = cm_cnt_ff + 1'b1;
            end else begin
               cm_wp_in = 1'b0;
               if (!cm_wp_ff) begin
                  state_in = BK_RUN;
               end
            end
         end
         BK_RUN: begin
            if (head_valid && out_free) begin
               pop      = 1'b1;
               rsp_load = 1'b1;
               case (head.op)
                  OP_RD_BSTAT:  r = bstat_ff;
                  OP_RD_BCTL:   r = bctl_ff;
                  OP_RD_STATUS: begin
                     bstat_in = bstat_ff & ~B_INT;
                     r        = ctl_ff;
                  end
                  OP_RD_TRACK:  r = trk_ff;
                  OP_RD_SECTOR: r = sec_ff;
                  OP_RD_DATA: begin
                     if (mode_ff == M_READ) begin
                        if (bc_ff == 8'd0 && bad_sector) begin
                           bstat_in = B_INT;
                           mode_in  = M_IDLE;
                           ctl_in   = S_RNF;
                        end else if (bc_ff == 8'd0 && !drive_ok) begin
                           bstat_in = B_INT;
                           mode_in  = M_IDLE;
                           ctl_in   = S_NR;
                        end else begin
                           if (bc_ff == 8'd0) begin
                              latched_in = sec_addr;
                              xfer_addr  = sec_addr;
                              bstat_in   = B_IN | B_INT;
                           end
                           if (bc_ff == 8'(SECTOR_BYTES - 1)) begin
                              mode_in = M_IDLE;
                              ctl_in  = 8'd0;
                           end
                           media_re    = 1'b1;
                           media_raddr = xfer_addr + MEDIA_AW'(bc_ff);
                           bc_in       = bc_ff + 1'b1;
                           rsp_load    = 1'b0;
                           state_in    = BK_MEDRD;
                        end
                     end else if (mode_ff == M_RADR) begin
                        if (bc_ff == 8'd0) begin
                           radr_sec_in = sec_ff;
                           bstat_in    = B_IN | B_INT;
                           r           = trk_ff;
                        end else if (bc_ff == 8'd2) begin
                           r = radr_sec_ff;
                        end
                        if (bc_ff == 8'(RADR_BYTES - 1)) begin
                           mode_in = M_IDLE;
                           ctl_in  = 8'd0;
                        end
                        bc_in = bc_ff + 1'b1;
                     end
                  end
                  OP_WR_BCTL: begin
                     bctl_in = d;
                     sel     = d[3:1];
                     if (sel > 3'd3) begin
                        sel = sel - 1'b1;
                     end
                     drv_in = sel[1:0];
                  end
                  OP_WR_CMD: begin
                     bstat_in = B_INT;
                     case (hi)
                        CMD_RESTORE: begin
                           trk_in = 8'd0;
                           ctl_in = S_TRK0;
                        end
                        CMD_SEEK: begin
                           if (dat_ff < TRACKS) begin
                              trk_in = dat_ff;
                              ctl_in = (dat_ff == 8'd0) ? S_TRK0 : 8'd0;
                           end else begin
                              ctl_in = S_RNF | ((trk_ff == 8'd0) ? S_TRK0 : 8'd0);
                           end
                        end
                        CMD_STEP, CMD_STEP_UPD: begin
                           ctl_in = S_RNF | ((trk_ff == 8'd0) ? S_TRK0 : 8'd0);
                        end
                        CMD_STEP_IN, CMD_STEP_IN_UPD, CMD_STEP_OUT, CMD_STEP_OUT_UPD: begin
                           if (d[4]) begin
                              new_trk = d[5] ? trk_ff - 1'b1 : trk_ff + 1'b1;
                           end
                           trk_in = new_trk;
                           ctl_in = ((new_trk < TRACKS) ? 8'd0 : S_RNF)
                                  | ((new_trk == 8'd0) ? S_TRK0 : 8'd0);
                        end
                        CMD_READ: begin
                           mode_in  = M_READ;
                           bc_in    = 8'd0;
                           ctl_in   = 8'd0;
                           bstat_in = B_IN;
                        end
                        CMD_WRITE: begin
                           mode_in  = M_WRITE;
                           bc_in    = 8'd0;
                           ctl_in   = 8'd0;
                           bstat_in = B_OUT;
                        end
                        CMD_GROUP_C: begin
                           if (d == CMD_READ_ADDR) begin
                              mode_in  = M_RADR;
                              bc_in    = 8'd0;
                              ctl_in   = 8'd0;
                              bstat_in = B_IN;
                           end else begin
                              ctl_in = S_CMD;
                           end
                        end
                        CMD_FORMAT: begin
                           mode_in   = M_FMT;
                           fphase_in = 2'd0;
                           ctl_in    = 8'd0;
                           bstat_in  = B_OUT;
                        end
                        CMD_FORCE_INT: begin
                           mode_in = M_IDLE;
                           ctl_in  = 8'd0;
                        end
                        CMD_READ_MULTI, CMD_WRITE_MULTI, CMD_READ_TRACK: begin
                           ctl_in = S_RNF;
                        end
                        default: ctl_in = S_CMD;
                     endcase
                  end
                  OP_WR_TRACK:  trk_in = d;
                  OP_WR_SECTOR: sec_in = d;
                  OP_WR_DATA: begin
                     if (mode_ff == M_WRITE) begin
                        if (bc_ff == 8'd0) begin
                           bstat_in = B_INT;
                           if (bad_sector) begin
                              st = S_RNF;
                           end else if (!drive_ok) begin
                              st = S_NR;
                           end else if (wprot) begin
                              st = S_WP;
                           end
                           latched_in = sec_addr;
                           xfer_addr  = sec_addr;
                        end
                        if (st != 8'd0) begin
                           mode_in = M_IDLE;
                           ctl_in  = st;
                        end else begin
                           if (bc_ff == 8'd0) begin
                              bstat_in = B_OUT | B_INT;
                           end
                           if (bc_ff < SECTOR_BYTES) begin
                              buf_we = 1'b1;
                           end
                           bc_in = bc_ff + 1'b1;
                           if (bc_in >= SECTOR_BYTES) begin
                              cm_base_in = xfer_addr;
                              cm_len_in  = 8'(SECTOR_BYTES);
                              cm_cap_in  = CAP_W'(SECTOR_BYTES);
                              cm_cnt_in  = 8'd0;
                              cm_wp_in   = 1'b0;
                              mode_in    = M_IDLE;
                              ctl_in     = 8'd0;
                              state_in   = BK_COMMIT;
                           end
                        end
                     end else if (mode_ff == M_FMT) begin
                        if (fphase_ff == 2'd0) begin
                           bstat_in = B_INT;
                           if (!drive_ok) begin
                              st = S_NR;
                           end else if (wprot) begin
                              st = S_WP;
                           end else if (trk_ff >= TRACKS) begin
                              st = S_RNF;
                           end
                           if (st != 8'd0) begin
                              mode_in = M_IDLE;
                              ctl_in  = st;
                           end else begin
                              latched_in = trk_base;
                              bstat_in   = B_OUT | B_INT;
                              fphase_in  = 2'd1;
                              fsec_in    = 5'd0;
                              fptr_in    = '0;
                              if (d == MARK_DATA) begin
                                 fphase_in = 2'd2;
                                 bc_in     = 8'd0;
                              end
                           end
                        end else if (fphase_ff == 2'd1) begin
                           if (d == MARK_DATA) begin
                              fphase_in = 2'd2;
                              bc_in     = 8'd0;
                           end
                        end else if (d != MARK_END) begin
                           if (bc_ff < SECTOR_BYTES) begin
                              buf_we = 1'b1;
                              bc_in  = bc_ff + 1'b1;
                           end
                        end else begin
                           fsec_in    = fsec_ff + 1'b1;
                           cm_base_in = latched_ff + MEDIA_AW'(fptr_ff);
                           cm_len_in  = bc_ff;
                           cm_cap_in  = (fptr_ff < TRACK_BYTES)
                                      ? CAP_W'(TRACK_BYTES) - CAP_W'(fptr_ff) : '0;
                           cm_cnt_in  = 8'd0;
                           cm_wp_in   = 1'b0;
                           fptr_in    = fptr_ff + FPTR_W'(bc_ff);
                           ctl_in     = 8'd0;
                           fphase_in  = 2'd1;
                           if (fsec_in == 5'(SECTORS_PER_TRACK)) begin
                              mode_in = M_IDLE;
                           end
                           state_in = BK_COMMIT;
                        end
                     end else begin
                        dat_in = d;
                     end
                  end
                  default: r = 8'd0;
               endcase
               rsp_in.rdata        = r;
               rsp_in.irq_pending  = bstat_in[1];
               rsp_in.data_request = bstat_in[3:2];
            end
         end
         default: state_in = BK_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == BK_CLEAR) begin
         media_mem[clr_row_ff] <= '0;
      end else if (media_we) begin
         media_mem[media_waddr[MEDIA_AW-1:LANE_W]][media_waddr[LANE_W-1:0]] <= buf_rd_ff;
      end
      if (media_re) begin
         rd_row_ff  <= media_mem[media_raddr[MEDIA_AW-1:LANE_W]];
         rd_lane_ff <= media_raddr[LANE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_waddr] <= buf_wdata;
      end
      if (buf_re) begin
         buf_rd_ff <= buf_mem[buf_raddr];
      end
   end

   always_ff @(posedge clock) begin
      latched_ff  <= latched_in;
      radr_sec_ff <= radr_sec_in;
      cm_base_ff  <= cm_base_in;
      cm_len_ff   <= cm_len_in;
      cm_cap_ff   <= cm_cap_in;
      cm_cnt_ff   <= cm_cnt_in;
      cm_idx_ff   <= cm_idx_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         mode_ff      <= M_IDLE;
         ctl_ff       <= '0;
         trk_ff       <= '0;
         sec_ff       <= '0;
         dat_ff       <= '0;
         bstat_ff     <= '0;
         bctl_ff      <= '0;
         bc_ff        <= '0;
         drv_ff       <= '0;
         fphase_ff    <= '0;
         fsec_ff      <= '0;
         fptr_ff      <= '0;
         clr_row_ff   <= '0;
         cm_wp_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         mode_ff    <= mode_in;
         ctl_ff     <= ctl_in;
         trk_ff     <= trk_in;
         sec_ff     <= sec_in;
         dat_ff     <= dat_in;
         bstat_ff   <= bstat_in;
         bctl_ff    <= bctl_in;
         bc_ff      <= bc_in;
         drv_ff     <= drv_in;
         fphase_ff  <= fphase_in;
         fsec_ff    <= fsec_in;
         fptr_ff    <= fptr_in;
         clr_row_ff <= clr_row_in;
         cm_wp_ff   <= cm_wp_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// File: hdl/floppy_disk_controller_regs_core.sv
// ----------------------------------------------------------------------------
// floppy_disk_controller_regs_core
// Bus-access level floppy controller with on-chip media memory.
// ----------------------------------------------------------------------------
// After reset the media memory is cleared one 16-byte row per cycle, all 64064
// rows, during which req_ready stays low. Register beats then complete at one
// per cycle while the response is taken; a data-port read during a sector read
// also passes through BK_MEDRD for the registered media read. The last byte of
// a sector write and the end mark of a formatted sector each add a copy from the
// sector buffer into media, one byte per cycle, before the next beat executes.
// ----------------------------------------------------------------------------
module floppy_disk_controller_regs_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fdcr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fdcr_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [3:0]        csr_wdata
);
   import fdcr_pkg::*;

   cfg_type  cfg_ff;
   item_type head;
   logic     head_valid, pop, clear_busy;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drive_present <= 4'hf;
         cfg_ff.write_protect <= 4'h0;
      end else if (csr_valid) begin
         if (csr_index == CSR_DRIVE_PRESENT) begin
            cfg_ff.drive_present <= csr_wdata;
         end else if (csr_index == CSR_WRITE_PROTECT) begin
            cfg_ff.write_protect <= csr_wdata;
         end
      end
   end

   fdcr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .clear_busy (clear_busy),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   fdcr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .clear_busy (clear_busy),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
